FILE: rtl/skbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbf_pkg: shared constants and types for the jump-blend Kalman filter
// Holds fixed-point formats, blend weights, register indexes and state codes.
// ----------------------------------------------------------------------------
package skbf_pkg;

  // Default number of fraction bits for samples, estimates and covariance.
  localparam int FRAC_BITS_DEF = 16;

  // Data widths fixed by the interface.
  localparam int DATA_W = 32;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 1;

  // Blend weights in Q0.16; they sum to exactly 1.0.
  localparam int W_SHIFT  = 16;
  localparam int WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] W_SAMPLE = 17'd25035;
  localparam logic [WEIGHT_W-1:0] W_LAST   = 17'd40501;

  // Operand A of the shared multiplier carries a 32-bit signed sample or
  // estimate, a 33-bit signed innovation or a 32-bit unsigned covariance.
  localparam int MUL_AW = 34;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE     = 1'd0;
  localparam logic [IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

  // Register reset values.
  localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = 32'd655;
  localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = 32'd65536;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PREP  = 9'b000000010,
    ST_BLEND = 9'b000000100,
    ST_PRED  = 9'b000001000,
    ST_ROUND = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_CORR  = 9'b001000000,
    ST_COV   = 9'b010000000,
    ST_EST   = 9'b100000000
  } seq_state_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;

endpackage

FILE: rtl/skbf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbf_mul: shared signed multiplier with a registered product
// The product register loads only when enabled, so a result can be held.
// ----------------------------------------------------------------------------
module skbf_mul
  import skbf_pkg::*;
#(
  parameter int BW = 18
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [MUL_AW-1:0]    a,
  input  logic signed [BW-1:0]        b,
  output logic signed [MUL_AW+BW-1:0] prod_r
);

  logic signed [MUL_AW+BW-1:0] prod_nxt;

  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: rtl/skbf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbf_div: restoring divider for the Kalman gain
// Computes floor(num * 2^FRAC_BITS / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module skbf_div
  import skbf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_ctrl_t            ctrl_in,
  output div_ctrl_t            ctrl_out,
  input  logic [DATA_W-1:0]    num,
  input  logic [DATA_W:0]      den,
  output logic [FRAC_BITS:0]   quot
);

  localparam int GW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(GW);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W+1:0] rem_r, rem_nxt;
  logic [DATA_W:0]   den_r, den_nxt;
  logic [GW-1:0]     q_r, q_nxt;
  logic              ge;
  logic [DATA_W+1:0] rem_sub;

  // The numerator never exceeds the denominator, so the remainder stays
  // below twice the denominator after each shift.
  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (ctrl_in.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {2'b00, num};
      // A zero denominator only occurs with a zero numerator; dividing by
      // one then gives the required zero gain.
      den_nxt  = (den == '0) ? {{DATA_W{1'b0}}, 1'b1} : den;
      q_nxt    = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[GW-2:0], ge};
      rem_nxt = {rem_sub[DATA_W:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(GW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign ctrl_out.start = 1'b0;
  assign ctrl_out.busy  = busy_r;
  assign quot           = q_r;

endmodule

FILE: rtl/scalar_kalman_jump_blend_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_jump_blend_filter_top: scalar Kalman filter with jump blending
// Sequencer around one shared multiplier and an iterative gain divider.
// ----------------------------------------------------------------------------
// Each sample transfer yields exactly one estimate transfer. The block works
// on one sample at a time: after a sample is taken, in_stall stays high
// while the bit-per-cycle gain divider and the four passes through the
// shared multiplier run, and longer only if the previous estimate is still
// waiting on out_stall. The estimate sits in an output register, so a new
// sample can be taken while the previous estimate waits. Samples and
// estimates are signed with FRAC_BITS fraction bits; the noise registers
// and the internal covariance are unsigned in the same format.
// Configuration writes take effect at once and should only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
module scalar_kalman_jump_blend_filter_top
  import skbf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Sample channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  // Estimate channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_estimate,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  // Gain width: the gain runs from zero up to exactly 1.0.
  localparam int GW     = FRAC_BITS + 1;
  // Operand B must hold either a blend weight or a gain, as signed values.
  localparam int MUL_BW = (GW + 1 > WEIGHT_W + 1) ? GW + 1 : WEIGHT_W + 1;
  localparam int PW     = MUL_AW + MUL_BW;
  localparam int CORR_W = DATA_W + 3;
  localparam int SUM_W  = DATA_W + 4;

  localparam logic signed [DATA_W:0] HALF_POS = (DATA_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [DATA_W:0] HALF_NEG = -HALF_POS;
  localparam logic [GW-1:0]          GAIN_ONE = GW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0]   BLEND_RND = PW'(1) << (W_SHIFT - 1);
  localparam logic signed [PW-1:0]   CORR_RND  = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [DATA_W-1:0] EST_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] EST_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration registers.
  logic [CFG_W-1:0] q_noise_r, q_noise_nxt;
  logic [CFG_W-1:0] r_noise_r, r_noise_nxt;

  // Filter state.
  logic signed [DATA_W-1:0] last_est_r, last_est_nxt;
  logic [DATA_W-1:0]        cov_r, cov_nxt;

  // Sequencer and working registers.
  seq_state_t               state_r, state_nxt;
  logic signed [DATA_W-1:0] z_r, z_nxt;
  logic signed [DATA_W:0]   innov_r, innov_nxt;
  logic [DATA_W-1:0]        p1_r, p1_nxt;
  logic                     jump_r, jump_nxt;
  logic signed [PW-1:0]     acc_r, acc_nxt;
  logic signed [DATA_W-1:0] pred_r, pred_nxt;
  logic signed [CORR_W-1:0] corr_r, corr_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_est_r, out_est_nxt;

  // Shared multiplier.
  logic                     mul_en;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PW-1:0]     prod;

  // Divider.
  div_ctrl_t                div_req;
  div_ctrl_t                div_sts;
  logic [DATA_W:0]          div_den;
  logic [GW-1:0]            gain;

  // Datapath helpers.
  logic                     in_xfer;
  logic                     out_free;
  logic [DATA_W:0]          p1_sum;
  logic signed [PW-1:0]     acc_rnd;
  logic signed [PW-1:0]     corr_rnd;
  logic signed [SUM_W-1:0]  est_sum;
  logic signed [DATA_W-1:0] est_sat;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Covariance plus process noise, saturated at the unsigned maximum in ST_PREP.
  assign p1_sum  = {1'b0, cov_r} + {1'b0, q_noise_r};
  assign div_den = {1'b0, p1_r} + {1'b0, r_noise_r};

  // Rounding to nearest with ties upward is an add of one half followed by
  // an arithmetic shift.
  assign acc_rnd  = acc_r + BLEND_RND;
  assign corr_rnd = prod + CORR_RND;

  // The new estimate, saturated to the signed output range.
  assign est_sum = SUM_W'(pred_r) + SUM_W'(corr_r);
  always_comb begin
    if (est_sum > SUM_W'(EST_MAX)) begin
      est_sat = EST_MAX;
    end else if (est_sum < SUM_W'(EST_MIN)) begin
      est_sat = EST_MIN;
    end else begin
      est_sat = est_sum[DATA_W-1:0];
    end
  end

  // Operand selection for the shared multiplier. The blend uses the two
  // weights in turn, then the correction term and the covariance update.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_PREP: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(z_r);
        mul_b  = MUL_BW'(W_SAMPLE);
      end
      ST_BLEND: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(last_est_r);
        mul_b  = MUL_BW'(W_LAST);
      end
      ST_CORR: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(innov_r);
        mul_b  = MUL_BW'(gain);
      end
      ST_COV: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'({2'b00, p1_r});
        mul_b  = MUL_BW'(GAIN_ONE - gain);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Configuration writes.
  always_comb begin
    q_noise_nxt = q_noise_r;
    r_noise_nxt = r_noise_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE:     q_noise_nxt = cfg_data;
        REG_MEASUREMENT_NOISE: r_noise_nxt = cfg_data;
        default: begin
          q_noise_nxt = q_noise_r;
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    z_nxt         = z_r;
    innov_nxt     = innov_r;
    p1_nxt        = p1_r;
    jump_nxt      = jump_r;
    acc_nxt       = acc_r;
    pred_nxt      = pred_r;
    corr_nxt      = corr_r;
    last_est_nxt  = last_est_r;
    cov_nxt       = cov_r;
    out_est_nxt   = out_est_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_req.start = 1'b0;
    div_req.busy  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          z_nxt     = in_sample;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // Innovation against the last estimate and the predicted covariance.
        innov_nxt = (DATA_W + 1)'(z_r) - (DATA_W + 1)'(last_est_r);
        p1_nxt    = p1_sum[DATA_W] ? {DATA_W{1'b1}} : p1_sum[DATA_W-1:0];
        state_nxt = ST_BLEND;
      end
      ST_BLEND: begin
        // The sample weight product is ready; the divider starts on the gain.
        acc_nxt       = prod;
        jump_nxt      = (innov_r >= HALF_POS) || (innov_r <= HALF_NEG);
        div_req.start = 1'b1;
        state_nxt     = ST_PRED;
      end
      ST_PRED: begin
        acc_nxt   = acc_r + prod;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        // A jump of one half or more switches to the blended prediction.
        pred_nxt  = jump_r ? acc_rnd[W_SHIFT +: DATA_W] : last_est_r;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_sts.busy) begin
          state_nxt = ST_CORR;
        end
      end
      ST_CORR: begin
        state_nxt = ST_COV;
      end
      ST_COV: begin
        corr_nxt  = corr_rnd[FRAC_BITS +: CORR_W];
        state_nxt = ST_EST;
      end
      ST_EST: begin
        // Wait here until the output register can take the new estimate.
        if (out_free) begin
          out_est_nxt   = est_sat;
          out_valid_nxt = 1'b1;
          last_est_nxt  = est_sat;
          cov_nxt       = prod[FRAC_BITS +: DATA_W];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      q_noise_r   <= PROCESS_NOISE_RST;
      r_noise_r   <= MEASUREMENT_NOISE_RST;
      last_est_r  <= '0;
      cov_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      q_noise_r   <= q_noise_nxt;
      r_noise_r   <= r_noise_nxt;
      last_est_r  <= last_est_nxt;
      cov_r       <= cov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r       <= z_nxt;
    innov_r   <= innov_nxt;
    p1_r      <= p1_nxt;
    jump_r    <= jump_nxt;
    acc_r     <= acc_nxt;
    pred_r    <= pred_nxt;
    corr_r    <= corr_nxt;
    out_est_r <= out_est_nxt;
  end

  skbf_mul #(
    .BW (MUL_BW)
  ) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  skbf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_in  (div_req),
    .ctrl_out (div_sts),
    .num      (p1_r),
    .den      (div_den),
    .quot     (gain)
  );

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;

endmodule

FILE: verif/skbf_estimate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbf_estimate_checker: scoreboard for the jump-blend Kalman filter
// Watches the sample, estimate and configuration ports, predicts each
// estimate from its own copy of the filter state and compares in order.
// ----------------------------------------------------------------------------
module skbf_estimate_checker
  import skbf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_estimate,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       mismatch_count,
  output int                       estimates_pending
);

  localparam longint EST_MAX = 64'sd2147483647;
  localparam longint EST_MIN = -64'sd2147483648;

  logic signed [DATA_W-1:0] expected_estimates[$];
  logic signed [DATA_W-1:0] est_q;
  logic [CFG_W-1:0]         q_noise;
  logic [CFG_W-1:0]         r_noise;
  logic [DATA_W-1:0]        cov_q;

  initial begin
    mismatch_count    = 0;
    estimates_pending = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns checker: %s", $time, msg);
  endtask

  // One filter step: updates the tracked estimate and covariance and returns
  // the saturated estimate that the block must emit for this sample.
  function automatic logic signed [DATA_W-1:0] kalman_update(
    input logic signed [DATA_W-1:0] sample
  );
    longint          z;
    longint          x;
    longint          abs_gap;
    longint          pred;
    longint          innov;
    longint          corr;
    longint          total;
    longint unsigned p1;
    longint unsigned den;
    longint unsigned gain;
    longint unsigned unity;
    logic signed [DATA_W-1:0] est;
    z       = sample;
    x       = est_q;
    abs_gap = (x > z) ? x - z : z - x;
    if (abs_gap >= (longint'(1) << (FRAC_BITS - 1))) begin
      pred = (z * longint'(W_SAMPLE) + x * longint'(W_LAST)
              + (longint'(1) << (W_SHIFT - 1))) >>> W_SHIFT;
    end else begin
      pred = x;
    end
    p1 = 64'(cov_q) + 64'(q_noise);
    if (p1 > 64'hFFFF_FFFF) begin
      p1 = 64'hFFFF_FFFF;
    end
    den   = p1 + 64'(r_noise);
    unity = 64'd1 << FRAC_BITS;
    gain  = (den == 0) ? 64'd0 : (p1 << FRAC_BITS) / den;
    innov = z - x;
    corr  = (longint'(gain) * innov + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    total = pred + corr;
    if (total > EST_MAX) begin
      est = 32'sh7FFF_FFFF;
    end else if (total < EST_MIN) begin
      est = 32'sh8000_0000;
    end else begin
      est = 32'(total);
    end
    cov_q = 32'(((unity - gain) * p1) >> FRAC_BITS);
    est_q = est;
    return est;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      est_q   = '0;
      cov_q   = '0;
      q_noise = PROCESS_NOISE_RST;
      r_noise = MEASUREMENT_NOISE_RST;
      expected_estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROCESS_NOISE:     q_noise = cfg_data;
          REG_MEASUREMENT_NOISE: r_noise = cfg_data;
          default: ;
        endcase
      end
      // The estimate side is checked before the new sample is queued, so a
      // transfer in the same cycle can never match its own expectation.
      if (out_valid && !out_stall) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch($sformatf("unexpected estimate %h", out_estimate));
        end else if (out_estimate !== expected_estimates[0]) begin
          report_mismatch($sformatf("estimate %h, expected %h",
                                    out_estimate, expected_estimates[0]));
          void'(expected_estimates.pop_front());
        end else begin
          void'(expected_estimates.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        expected_estimates.push_back(kalman_update(in_sample));
      end
    end
    estimates_pending <= expected_estimates.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the scalar jump-blend Kalman filter
// Drives samples and noise settings through several phases, stalls the
// estimate side at random and leaves all checking to the estimate checker.
// ----------------------------------------------------------------------------
module tb_top;
  import skbf_pkg::*;

  localparam int FRAC_BITS    = FRAC_BITS_DEF;
  // Cycles to let pass once the last estimate has arrived, covering the
  // sequencer's per-sample latency with some margin.
  localparam int SETTLE       = FRAC_BITS + 12;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 210;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [CFG_W-1:0] NOISE_MAX = 32'hFFFF_FFFF;

  // All inputs of the block start at known values at time zero.
  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic signed [DATA_W-1:0] in_sample    = '0;
  logic                     out_stall    = 1'b0;
  logic                     cfg_we       = 1'b0;
  logic [IDX_W-1:0]         cfg_index    = '0;
  logic [CFG_W-1:0]         cfg_data     = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_estimate;
  int                       mismatch_count;
  int                       estimates_pending;

  // Set by the stimulus to ask the estimate side for one long hold-off.
  logic                     hold_req     = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  scalar_kalman_jump_blend_filter_top #(
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_estimate (out_estimate),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  skbf_estimate_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_estimate      (out_estimate),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .estimates_pending (estimates_pending)
  );

  // Writes the process and then the measurement noise register on consecutive
  // edges. The write enable stays high across both writes and drops once after the second one.
  task automatic write_noise(input logic [CFG_W-1:0] q, input logic [CFG_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PROCESS_NOISE;
    cfg_data  <= q;
    @(posedge clk);
    cfg_index <= REG_MEASUREMENT_NOISE;
    cfg_data  <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offers one sample and returns right after the edge at which the transfer
  // happened. Valid is not dropped here, so back-to-back samples keep it high.
  task automatic offer_sample(input logic signed [DATA_W-1:0] s);
    in_sample <= s;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Idles the sample side for a number of cycles; zero keeps valid high.
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Gap before the next sample: mostly none or short, now and then long.
  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return 0;
    end else if (pick < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  // Waits until every predicted estimate has been transferred, then lets the
  // sequencer settle so a following register write finds the block idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (estimates_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Next random sample. Many samples track the previous one with small
  // noise, so the filter spends time on both sides of the half-unit jump
  // threshold; the rest probe the threshold, small values, the full range
  // and the extremes.
  function automatic logic signed [DATA_W-1:0] next_sample(
    input logic signed [DATA_W-1:0] prev
  );
    int          pick;
    logic [31:0] delta;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      delta = $urandom_range(0, 32'h1FFFF);
      return prev + delta - 32'h10000;
    end else if (pick < 60) begin
      delta = 32'h7FFF + $urandom_range(0, 2);
      return ($urandom_range(0, 1) == 1) ? prev + delta : prev - delta;
    end else if (pick < 75) begin
      delta = $urandom_range(0, 32'h1FFFFF);
      return delta - 32'h100000;
    end else if (pick < 90) begin
      return $urandom;
    end
    case ($urandom_range(0, 5))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh7FFF_FFFE;
      3:       return 32'sh8000_0001;
      4:       return -32'sd1;
      default: return '0;
    endcase
  endfunction

  // Estimate-side stall pattern, in segments of random level and length.
  // Quiet stretches with no stall alternate with short and long hold-offs.
  // The first hold request seen turns into one long hold-off during which
  // the sample side keeps offering, so the block fills and stalls its input.
  initial begin
    int   len;
    int   pick;
    logic lvl;
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        lvl       = 1'b1;
        len       = HOLD_CYCLES;
      end else if (pick < 55) begin
        lvl = 1'b0;
        len = $urandom_range(1, 6);
      end else if (pick < 85) begin
        lvl = 1'b1;
        len = $urandom_range(1, 3);
      end else if (pick < 93) begin
        lvl = 1'b0;
        len = $urandom_range(40, 150);
      end else if (pick < 98) begin
        lvl = 1'b1;
        len = $urandom_range(5, 30);
      end else begin
        lvl = 1'b1;
        len = $urandom_range(40, 90);
      end
      repeat (len) begin
        @(posedge clk);
        out_stall <= lvl;
      end
    end
  end

  // Main stimulus.
  initial begin
    logic signed [DATA_W-1:0] s;
    logic [CFG_W-1:0]         q;
    logic [CFG_W-1:0]         r;
    int                       ph;
    int                       i;
    bit                       burst;
    s = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // With both noise terms at zero and the covariance fresh from reset, the
    // gain denominator is zero: the estimate only moves on a jump. The first
    // samples sit just inside and exactly on the jump threshold.
    write_noise('0, '0);
    offer_sample(32'sh0000_0000);
    offer_sample(32'sh0000_7FFF);
    offer_sample(-32'sh0000_7FFF);
    offer_sample(32'sh0000_8000);
    offer_sample(32'sh0000_8000);
    wait_drained();

    // Zero measurement noise gives a gain of exactly one and clears the
    // covariance. Jumps to the extremes then push the estimate past the
    // signed range in both directions, so it must saturate.
    write_noise(PROCESS_NOISE_RST, '0);
    offer_sample(32'sh7FFF_FFFF);
    offer_sample(32'sh7FFF_FFFF);
    offer_sample(32'sh8000_0000);
    offer_sample(32'sh8000_0000);
    offer_sample(32'sh7FFF_FFFF);
    offer_sample(32'sh8000_0000);
    offer_sample(32'sh0000_0000);
    wait_drained();

    // Largest noise terms drive the covariance sum into saturation.
    write_noise(NOISE_MAX, NOISE_MAX);
    offer_sample(32'sh7FFF_FFFF);
    offer_sample(32'sh8000_0000);
    offer_sample(32'sh0000_0001);
    offer_sample(-32'sd1);
    offer_sample(32'sh0000_0000);
    wait_drained();

    // Reset values, with plain unit steps and the extremes.
    write_noise(PROCESS_NOISE_RST, MEASUREMENT_NOISE_RST);
    offer_sample(32'sh0001_0000);
    offer_sample(-32'sh0001_0000);
    offer_sample(32'sh7FFF_FFFF);
    offer_sample(32'sh8000_0000);
    offer_sample(32'sh0000_4000);
    wait_drained();

    // Random phases, each with its own noise setting. Some run with no gaps
    // on the sample side at all.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin q = PROCESS_NOISE_RST; r = MEASUREMENT_NOISE_RST; end
        1: begin q = '0;                r = NOISE_MAX;             end
        2: begin q = NOISE_MAX;         r = '0;                    end
        3: begin q = $urandom;          r = $urandom;              end
        4: begin q = $urandom_range(0, 32'h1_0000); r = $urandom_range(0, 32'h4_0000); end
        5: begin q = '0;                r = '0;                    end
        6: begin q = $urandom;          r = $urandom_range(0, 32'h10_0000); end
        default: begin q = $urandom_range(0, 32'h800); r = $urandom; end
      endcase
      write_noise(q, r);
      burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) begin
          hold_req = 1'b1;
        end
        s = next_sample(s);
        offer_sample(s);
        pause_sender(burst ? 0 : sender_gap());
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/skbf_pkg.sv
rtl/skbf_mul.sv
rtl/skbf_div.sv
rtl/scalar_kalman_jump_blend_filter_top.sv
verif/skbf_estimate_checker.sv
verif/tb_top.sv
